/* hw/rtl/servo_position_ramp_assert.svh */
// servo_position_ramp_assert.svh: assertion macros for the servo position ramp
// depends on: a clk and an arst_n signal in the scope where a macro is used
`ifndef SERVO_POSITION_RAMP_ASSERT_SVH
`define SERVO_POSITION_RAMP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SPR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the cycle after the antecedent
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/spr_pkg.sv */
// spr_pkg: types, codes, constants and helper functions of the servo position ramp
// depends on: nothing
package spr_pkg;

	// timing constants
	localparam int TICKS_PER_MS = 1000;
	localparam int ELAPSED_W    = 27;
	localparam int DUR_W        = 16;
	localparam int THR_W        = DUR_W + $clog2(TICKS_PER_MS + 1);
	localparam int CMP_W        = (ELAPSED_W > THR_W) ? ELAPSED_W : THR_W;

	// shared divider: one quotient bit per cycle
	localparam int DIV_STEPS = DUR_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	localparam logic [6:0] POS_MAX = 7'd100;

	// command kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SET  = 2'd1;
	localparam logic [1:0] KIND_MOVE = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       percent;
		logic [DUR_W-1:0] duration_ms;
		logic [7:0]       step_count;
	} cmd_t;

	typedef struct packed {
		logic [7:0] angle_deg;
		logic [6:0] position_percent;
		logic       moving;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV1,
		ST_SEL,
		ST_DIV2,
		ST_MUL,
		ST_TICK,
		ST_STEP,
		ST_TRIM,
		ST_EMIT
	} state_t;

	// floor(p * 9 / 5): p * 9 / 5 taken as p * 9 * 205 / 1024, exact for 0..100
	function automatic logic [7:0] angle_of(input logic [6:0] p);
		logic [17:0] prod;
		prod = 18'(p) * 18'd1845;
		return prod[17:10];
	endfunction

	// magnitude of a small two's complement value
	function automatic logic [7:0] abs8(input logic [7:0] v);
		return v[7] ? 8'(~v + 8'd1) : v;
	endfunction

endpackage

/* hw/rtl/servo_position_ramp.sv */
// servo_position_ramp: servo position ramp generator with a shared serial divider
// depends on: spr_pkg
//
// channel  dir  handshake              payload
// cmd      in   cmd_valid / cmd_stall  spr_pkg::cmd_t (kind, percent, duration_ms, step_count)
// res      out  res_valid / res_stall  spr_pkg::res_t (angle_deg, position_percent, moving)
//
// a tick goes through the tick state while a move is on, and on a step through step, trim
// and emit; a set goes straight to emit; a ramped move makes two passes of 16 iterations
// through the one divider; an unused kind or a move onto the current position stays idle
// reset clears the sequencer, ramp state and result valid flag at once, no clearing pass
// the result register lets the next command in while a result waits on res_stall;
// only a command that must emit waits for that register to free up
module servo_position_ramp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  spr_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output spr_pkg::res_t res
);

	spr_pkg::state_t state_q, state_d;

	// divider registers
	logic [spr_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                rem_q;
	logic [spr_pkg::DUR_W-1:0] quo_q;
	logic [7:0]                div_q;

	// move setup registers
	logic                      sign_q;
	logic [6:0]                absdiff_q;
	logic [spr_pkg::DUR_W-1:0] dur_q;

	// ramp state
	logic                          move_q;
	logic [6:0]                    cur_q;
	logic [6:0]                    tgt_q;
	logic [7:0]                    delta_q;
	logic [spr_pkg::THR_W-1:0]     thr_q;
	logic [spr_pkg::ELAPSED_W-1:0] elapsed_q;

	logic          res_valid_q;
	spr_pkg::res_t res_q;

	logic                          cmd_acc;
	logic                          res_load;
	logic [6:0]                    pct_move;
	logic [6:0]                    pct_set;
	logic [7:0]                    diff_in;
	logic [6:0]                    absdiff_in;
	logic [8:0]                    shifted;
	logic [9:0]                    trial;
	logic                          q_bit;
	logic [7:0]                    rem_nx;
	logic [spr_pkg::ELAPSED_W-1:0] elapsed_inc;
	logic                          fire;
	logic [8:0]                    sum;
	logic [6:0]                    pos_new;
	logic [7:0]                    rem_diff;
	logic [7:0]                    q_delta;

	assign cmd_stall = (state_q != spr_pkg::ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_load  = (state_q == spr_pkg::ST_EMIT) && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// requested position, clamped for a move and zeroed when out of range for a set
	assign pct_move   = (cmd.percent > 8'(spr_pkg::POS_MAX)) ? spr_pkg::POS_MAX
		: cmd.percent[6:0];
	assign pct_set    = (cmd.percent > 8'(spr_pkg::POS_MAX)) ? 7'd0 : cmd.percent[6:0];
	assign diff_in    = {1'b0, pct_move} - {1'b0, cur_q};
	assign absdiff_in = 7'(spr_pkg::abs8(diff_in));

	// one restoring division step
	assign shifted = {rem_q, quo_q[spr_pkg::DUR_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};
	assign q_bit   = !trial[9];
	assign rem_nx  = q_bit ? trial[7:0] : shifted[7:0];

	// signed per-step delta from the first quotient
	assign q_delta = sign_q ? 8'(~{1'b0, quo_q[6:0]} + 8'd1) : {1'b0, quo_q[6:0]};

	// tick counter with saturation and threshold compare
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign fire = spr_pkg::CMP_W'(elapsed_inc) > spr_pkg::CMP_W'(thr_q);

	// next position, clamped to 0..100
	assign sum = {2'b00, cur_q} + {delta_q[7], delta_q};
	always_comb begin
		if (sum[8]) begin
			pos_new = 7'd0;
		end else if (sum[7:0] > 8'(spr_pkg::POS_MAX)) begin
			pos_new = spr_pkg::POS_MAX;
		end else begin
			pos_new = sum[6:0];
		end
	end

	assign rem_diff = {1'b0, tgt_q} - {1'b0, cur_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spr_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					unique case (cmd.kind)
						spr_pkg::KIND_TICK: state_d = move_q ? spr_pkg::ST_TICK : spr_pkg::ST_IDLE;
						spr_pkg::KIND_SET:  state_d = spr_pkg::ST_EMIT;
						spr_pkg::KIND_MOVE: begin
							state_d = (pct_move == cur_q) ? spr_pkg::ST_IDLE : spr_pkg::ST_DIV1;
						end
						default:            state_d = spr_pkg::ST_IDLE;
					endcase
				end
			end
			spr_pkg::ST_DIV1: begin
				if (cnt_q == '0) state_d = spr_pkg::ST_SEL;
			end
			spr_pkg::ST_SEL:  state_d = spr_pkg::ST_DIV2;
			spr_pkg::ST_DIV2: begin
				if (cnt_q == '0) state_d = spr_pkg::ST_MUL;
			end
			spr_pkg::ST_MUL:  state_d = spr_pkg::ST_IDLE;
			spr_pkg::ST_TICK: state_d = fire ? spr_pkg::ST_STEP : spr_pkg::ST_IDLE;
			spr_pkg::ST_STEP: state_d = spr_pkg::ST_TRIM;
			spr_pkg::ST_TRIM: state_d = spr_pkg::ST_EMIT;
			spr_pkg::ST_EMIT: begin
				if (res_load) state_d = spr_pkg::ST_IDLE;
			end
			default:          state_d = spr_pkg::ST_IDLE;
		endcase
	end

	// shared divider and move setup operands
	always_ff @(posedge clk) begin
		case (state_q)
			spr_pkg::ST_IDLE: begin
				if (cmd_acc && cmd.kind == spr_pkg::KIND_MOVE) begin
					sign_q    <= diff_in[7];
					absdiff_q <= absdiff_in;
					dur_q     <= cmd.duration_ms;
					div_q     <= (cmd.step_count == 8'd0) ? 8'd1 : cmd.step_count;
					rem_q     <= '0;
					quo_q     <= spr_pkg::DUR_W'(absdiff_in);
					cnt_q     <= spr_pkg::DIV_LAST;
				end
			end
			spr_pkg::ST_DIV1, spr_pkg::ST_DIV2: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[spr_pkg::DUR_W-2:0], q_bit};
				cnt_q <= cnt_q - 1'b1;
			end
			spr_pkg::ST_SEL: begin
				// more steps than the distance allows: one percent per step instead
				if (quo_q == '0) div_q <= {1'b0, absdiff_q};
				rem_q <= '0;
				quo_q <= dur_q;
				cnt_q <= spr_pkg::DIV_LAST;
			end
			default: begin
			end
		endcase
	end

	// ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_q    <= 1'b0;
			cur_q     <= '0;
			tgt_q     <= '0;
			delta_q   <= '0;
			thr_q     <= '0;
			elapsed_q <= '0;
		end else begin
			case (state_q)
				spr_pkg::ST_IDLE: begin
					if (cmd_acc && cmd.kind == spr_pkg::KIND_SET) cur_q <= pct_set;
					if (cmd_acc && cmd.kind == spr_pkg::KIND_MOVE && pct_move != cur_q) begin
						tgt_q <= pct_move;
					end
				end
				spr_pkg::ST_SEL: begin
					if (quo_q == '0) begin
						delta_q <= sign_q ? 8'hff : 8'd1;
					end else begin
						delta_q <= q_delta;
					end
				end
				spr_pkg::ST_MUL: begin
					thr_q     <= spr_pkg::THR_W'(quo_q) * spr_pkg::THR_W'(spr_pkg::TICKS_PER_MS);
					move_q    <= 1'b1;
					elapsed_q <= '0;
				end
				spr_pkg::ST_TICK: begin
					elapsed_q <= fire ? '0 : elapsed_inc;
				end
				spr_pkg::ST_STEP: begin
					cur_q <= pos_new;
					if (pos_new == tgt_q) move_q <= 1'b0;
				end
				spr_pkg::ST_TRIM: begin
					// shorten the last step so it lands on the target
					if (spr_pkg::abs8(delta_q) > spr_pkg::abs8(rem_diff)) delta_q <= rem_diff;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.angle_deg        <= spr_pkg::angle_of(cur_q);
			res_q.position_percent <= cur_q;
			res_q.moving           <= move_q;
		end
	end

endmodule

/* hw/rtl/spr_checker.sv */
// spr_checker: port-level checks for the servo position ramp, bound to the top level
// depends on: spr_pkg, servo_position_ramp_assert.svh
`include "servo_position_ramp_assert.svh"

module spr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input spr_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_stall,
	input spr_pkg::res_t res
);

	logic set_acc;
	logic angle_ok;

	assign set_acc  = cmd_valid && !cmd_stall && (cmd.kind == spr_pkg::KIND_SET);
	assign angle_ok = (res.position_percent <= spr_pkg::POS_MAX)
		&& (res.angle_deg == spr_pkg::angle_of(res.position_percent));

	// a stalled result transaction holds
	`SPR_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result moved")

	// an accepted immediate set keeps the block busy in the following cycle
	`SPR_ASSERT_NEXT(a_busy_after_set, set_acc, cmd_stall, "set taken without busy cycle")

	// a new result only comes out of command processing
	`SPR_ASSERT_SAME(a_res_from_work, $rose(res_valid), $past(cmd_stall), "result without work")

	// angle follows position and position stays in range
	`SPR_ASSERT_SAME(a_angle_match, res_valid, angle_ok, "angle does not match position")

endmodule

bind servo_position_ramp spr_checker u_spr_checker (.*);

/* tb/spr_result_checker.sv */
// spr_result_checker: predicts servo ramp results from accepted commands and checks them
// depends on: spr_pkg, clocked beside servo_position_ramp in tb_servo_position_ramp
module spr_result_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  spr_pkg::cmd_t cmd,
	input  logic          res_valid,
	input  logic          res_stall,
	input  spr_pkg::res_t res,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TICK_SAT = (1 << spr_pkg::ELAPSED_W) - 1;

	// predicted ramp state
	bit              ramp_on;
	bit [6:0]        pos_now;
	bit [6:0]        pos_goal;
	bit signed [7:0] step_by;
	bit [15:0]       period_ms;
	bit [26:0]       ticks_seen;

	// results still owed by the block, oldest first
	spr_pkg::res_t due_results[$];
	spr_pkg::res_t want;

	// result for the current position
	function automatic spr_pkg::res_t position_result();
		spr_pkg::res_t r;
		r.angle_deg        = 8'(int'(pos_now) * 9 / 5);
		r.position_percent = pos_now;
		r.moving           = ramp_on;
		return r;
	endfunction

	// advance the predicted state by one command
	task automatic apply_command(input spr_pkg::cmd_t c);
		int goal;
		int span;
		int n;
		int q;
		int mag_step;
		int mag_left;
		longint threshold;
		case (c.kind)
			spr_pkg::KIND_SET: begin
				pos_now = (c.percent > 8'd100) ? 7'd0 : c.percent[6:0];
				due_results.push_back(position_result());
			end
			spr_pkg::KIND_MOVE: begin
				goal = (c.percent > 8'd100) ? 100 : int'(c.percent);
				// a move onto the current position changes nothing
				if (goal != int'(pos_now)) begin
					n         = (c.step_count == 8'd0) ? 1 : int'(c.step_count);
					span      = goal - int'(pos_now);
					q         = span / n;
					period_ms = 16'(int'(c.duration_ms) / n);
					// more steps than distance: one percent per step
					if (q == 0) begin
						q         = (span > 0) ? 1 : -1;
						period_ms = 16'(int'(c.duration_ms) / ((span > 0) ? span : -span));
					end
					pos_goal   = 7'(goal);
					step_by    = 8'(q);
					ramp_on    = 1'b1;
					ticks_seen = '0;
				end
			end
			spr_pkg::KIND_TICK: begin
				if (ramp_on) begin
					if (ticks_seen != TICK_SAT)
						ticks_seen = ticks_seen + 27'd1;
					threshold = longint'(period_ms) * spr_pkg::TICKS_PER_MS;
					if (longint'(ticks_seen) > threshold) begin
						ticks_seen = '0;
						q = int'(pos_now) + int'(step_by);
						if (q > 100)
							q = 100;
						else if (q < 0)
							q = 0;
						pos_now = 7'(q);
						if (pos_now == pos_goal)
							ramp_on = 1'b0;
						// trim the last step so the target is hit exactly
						span     = int'(pos_goal) - q;
						mag_step = (step_by < 0) ? -int'(step_by) : int'(step_by);
						mag_left = (span < 0) ? -span : span;
						if (mag_step > mag_left)
							step_by = 8'(span);
						due_results.push_back(position_result());
					end
				end
			end
			default: ;
		endcase
	endtask

	// watch both channels: check results first, then fold in the new command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_on    = 1'b0;
			pos_now    = '0;
			pos_goal   = '0;
			step_by    = '0;
			period_ms  = '0;
			ticks_seen = '0;
			due_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with none expected, actual angle %0d pos %0d moving %0b",
						$time, res.angle_deg, res.position_percent, res.moving);
					errors <= errors + 1;
				end else begin
					want = due_results.pop_front();
					if (res.angle_deg !== want.angle_deg ||
						res.position_percent !== want.position_percent ||
						res.moving !== want.moving) begin
						$display("%0t: expected angle %0d pos %0d moving %0b, actual angle %0d pos %0d moving %0b",
							$time, want.angle_deg, want.position_percent, want.moving,
							res.angle_deg, res.position_percent, res.moving);
						errors <= errors + 1;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				apply_command(cmd);
			pending <= due_results.size();
		end
	end

endmodule

/* tb/tb_servo_position_ramp.sv */
// tb_servo_position_ramp: drives ticks, sets and ramped moves into servo_position_ramp
// depends on: spr_pkg, servo_position_ramp, spr_result_checker
module tb_servo_position_ramp;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int ITEM_GOAL    = 1700;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          res_stall = 1'b0;
	logic          quiet     = 1'b0;
	spr_pkg::cmd_t cmd       = '0;
	logic          cmd_stall;
	logic          res_valid;
	spr_pkg::res_t res;
	int            errors;
	int            pending;
	int            cycles     = 0;
	int            items_sent = 0;

	servo_position_ramp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	spr_result_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.errors    (errors),
		.pending   (pending)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side back-pressure, off during the quiet stretch
	always @(negedge clk) begin
		res_stall <= !quiet && ($urandom_range(0, 99) < 8);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** servo_position_ramp: FAILED **");
			$finish;
		end
	end

	// one command transaction, with random gaps ahead of it; called at a falling edge
	task automatic issue(input logic [1:0] kind, input logic [7:0] pct,
		input logic [15:0] dur, input logic [7:0] steps);
		spr_pkg::cmd_t c;
		c.kind        = kind;
		c.percent     = pct;
		c.duration_ms = dur;
		c.step_count  = steps;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
		if (kind != KIND_NONE)
			items_sent++;
	endtask

	// a run of ticks, optionally broken by sets and unused kinds
	task automatic tick_run(input int n, input bit mixed);
		int r;
		for (int i = 0; i < n; i++) begin
			r = mixed ? $urandom_range(0, 99) : 99;
			if (r < 3)
				issue(spr_pkg::KIND_SET, 8'($urandom), 16'($urandom), 8'($urandom));
			else if (r < 5)
				issue(KIND_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
			else
				issue(spr_pkg::KIND_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	// hold off the sender until every owed result is back
	task automatic drain();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	initial begin
		int r;
		int pct;
		int steps;
		int dur;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// idle tick, unused kind, move onto the current position
		issue(spr_pkg::KIND_TICK, 8'd0, 16'd0, 8'd0);
		issue(KIND_NONE, 8'hff, 16'hffff, 8'hff);
		issue(spr_pkg::KIND_MOVE, 8'd0, 16'hffff, 8'hff);
		// immediate sets: above range, top of range, just above range
		issue(spr_pkg::KIND_SET, 8'hff, 16'd0, 8'd0);
		issue(spr_pkg::KIND_SET, 8'd100, 16'd0, 8'd0);
		issue(spr_pkg::KIND_SET, 8'd101, 16'd0, 8'd0);
		// clamped target with zero steps, one jump, then an idle tick
		issue(spr_pkg::KIND_MOVE, 8'hff, 16'd0, 8'd0);
		tick_run(2, 1'b0);
		// three even steps and a trimmed last one
		issue(spr_pkg::KIND_SET, 8'd0, 16'd0, 8'd0);
		issue(spr_pkg::KIND_MOVE, 8'd10, 16'd2, 8'd3);
		tick_run(5, 1'b0);
		// more steps than distance, then a set past the target so it never lands
		issue(spr_pkg::KIND_MOVE, 8'd5, 16'd0, 8'd20);
		tick_run(2, 1'b0);
		issue(spr_pkg::KIND_SET, 8'd0, 16'd0, 8'd0);
		tick_run(3, 1'b0);
		// one ms period: the step fires on the tick after the threshold
		issue(spr_pkg::KIND_MOVE, 8'd50, 16'd1, 8'd1);
		tick_run(1001, 1'b0);
		// longest duration, set during the move, very slow one percent steps
		issue(spr_pkg::KIND_MOVE, 8'd100, 16'hffff, 8'd1);
		tick_run(3, 1'b0);
		issue(spr_pkg::KIND_SET, 8'd7, 16'd0, 8'd0);
		issue(spr_pkg::KIND_MOVE, 8'd20, 16'hffff, 8'hff);
		tick_run(3, 1'b0);
		issue(spr_pkg::KIND_MOVE, 8'd90, 16'd0, 8'd1);
		tick_run(2, 1'b0);
		drain();

		// random part: mostly ramps followed by tick runs
		while (items_sent < ITEM_GOAL) begin
			quiet <= (items_sent >= 1150 && items_sent < 1450);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				pct   = ($urandom_range(0, 9) == 0) ? $urandom_range(101, 255)
					: $urandom_range(0, 100);
				steps = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 12);
				r     = $urandom_range(0, 99);
				dur   = (r < 60) ? 0 : (r < 85) ? $urandom_range(0, steps + 1)
					: $urandom_range(0, 65535);
				issue(spr_pkg::KIND_MOVE, 8'(pct), 16'(dur), 8'(steps));
				tick_run($urandom_range(1, 110), 1'b1);
				if ($urandom_range(0, 99) < 5)
					drain();
			end else if (r < 85) begin
				issue(spr_pkg::KIND_SET, 8'($urandom), 16'($urandom), 8'($urandom));
			end else if (r < 93) begin
				issue(KIND_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
			end else begin
				tick_run($urandom_range(1, 5), 1'b1);
			end
		end

		// let the last results come home
		quiet <= 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("** servo_position_ramp: PASSED **");
		else
			$display("** servo_position_ramp: FAILED **");
		$finish;
	end

endmodule
